[sv/tcca_pkg.sv]
// shared types and constants for the timed color channel animator
// no dependencies; imported by every other file of the block
`default_nettype none

package tcca_pkg;

    localparam int CHANNELS = 4;

    localparam int COLOR_W   = 8;
    localparam int PERIOD_W  = 24;
    localparam int ACC_W     = 25;
    localparam int PACK_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [ACC_W-1:0]    ACC_MAX      = {ACC_W{1'b1}};
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 24'd500000;
    localparam logic [PACK_W-1:0]   RESET_MIN    = 32'h0000_0000;
    localparam logic [PACK_W-1:0]   RESET_MAX    = 32'hFFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COLORS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLORS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COLORS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STEPS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DIRECTION = 3'd6;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef enum logic [1:0] {
        MODE_BOUNCE   = 2'd0,
        MODE_MIN_MAX  = 2'd1,
        MODE_WAIT_ALL = 2'd2,
        MODE_WAIT_DIR = 2'd3
    } t_anim_mode;

    typedef struct packed {
        t_anim_mode mode;
        logic       direction_down;
    } t_chan_ctrl;

endpackage

`default_nettype wire

[sv/tcca_in_if.sv]
// input channel of the animator: tick or restart items
// uses tcca_pkg for field widths
`default_nettype none

interface tcca_in_if;
    import tcca_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [PERIOD_W-1:0] elapsed_time;

    modport source (output valid, output kind, output elapsed_time, input ready);
    modport sink   (input valid, input kind, input elapsed_time, output ready);
endinterface

`default_nettype wire

[sv/tcca_out_if.sv]
// result channel of the animator: step flag and packed colors
// uses tcca_pkg for field widths
`default_nettype none

interface tcca_out_if;
    import tcca_pkg::*;

    logic              valid;
    logic              ready;
    logic              stepped;
    logic [PACK_W-1:0] colors_now;

    modport source (output valid, output stepped, output colors_now, input ready);
    modport sink   (input valid, input stepped, input colors_now, output ready);
endinterface

`default_nettype wire

[sv/tcca_accum.sv]
// time accumulator: saturating add of elapsed time and period compare
// uses tcca_pkg
`default_nettype none

module tcca_accum (
    input  wire logic [tcca_pkg::ACC_W-1:0]    i_acc,
    input  wire logic [tcca_pkg::PERIOD_W-1:0] i_elapsed,
    input  wire logic [tcca_pkg::PERIOD_W-1:0] i_period,
    output logic      [tcca_pkg::ACC_W-1:0]    o_acc,
    output logic                               o_step
);
    import tcca_pkg::*;

    logic [ACC_W:0]   w_sum;
    logic [ACC_W-1:0] w_sat;
    logic [ACC_W-1:0] w_period;

    always_comb begin
        w_sum    = {1'b0, i_acc} + {2'b00, i_elapsed};
        w_sat    = w_sum[ACC_W] ? ACC_MAX : w_sum[ACC_W-1:0];
        w_period = {1'b0, i_period};
        o_step   = (w_sat >= w_period);
        o_acc    = o_step ? (w_sat - w_period) : w_sat;
    end
endmodule

`default_nettype wire

[sv/tcca_channel.sv]
// next color, step and done flag for one color channel
// uses tcca_pkg
`default_nettype none

module tcca_channel (
    input  wire tcca_pkg::t_chan_ctrl              i_ctrl,
    input  wire logic [tcca_pkg::COLOR_W-1:0]      i_color,
    input  wire logic [tcca_pkg::COLOR_W-1:0]      i_step,
    input  wire logic [tcca_pkg::COLOR_W-1:0]      i_lo,
    input  wire logic [tcca_pkg::COLOR_W-1:0]      i_hi,
    output logic      [tcca_pkg::COLOR_W-1:0]      o_color,
    output logic      [tcca_pkg::COLOR_W-1:0]      o_step,
    output logic                                   o_done
);
    import tcca_pkg::*;

    logic signed [COLOR_W+1:0] w_c;
    logic signed [COLOR_W+1:0] w_s;
    logic signed [COLOR_W+1:0] w_sum;
    logic signed [COLOR_W+1:0] w_lo;
    logic signed [COLOR_W+1:0] w_hi;
    logic signed [COLOR_W+1:0] w_next2;
    logic signed [COLOR_W+1:0] w_target;
    logic [COLOR_W-1:0]        w_neg;
    logic                      w_zero;
    logic                      w_stop;

    always_comb begin
        w_c      = {2'b00, i_color};
        w_s      = {{2{i_step[COLOR_W-1]}}, i_step};
        w_sum    = w_c + w_s;
        w_lo     = {2'b00, i_lo};
        w_hi     = {2'b00, i_hi};
        w_next2  = {2'b00, w_sum[COLOR_W-1:0]} + w_s;
        w_neg    = COLOR_W'(0) - i_step;
        w_zero   = (i_step == '0);
        w_target = i_ctrl.direction_down ? w_lo : w_hi;

        o_color = i_color;
        o_step  = i_step;
        o_done  = 1'b1;
        w_stop  = 1'b0;

        if (!w_zero) begin
            o_done = 1'b0;
            case (i_ctrl.mode)
                MODE_BOUNCE: begin
                    if (w_sum[COLOR_W+1:COLOR_W] != 2'b00) begin
                        o_step  = w_neg;
                        o_color = i_color + w_neg;
                    end else begin
                        o_color = w_sum[COLOR_W-1:0];
                    end
                end
                MODE_MIN_MAX: begin
                    o_color = w_sum[COLOR_W-1:0];
                    if (w_next2 == w_lo || w_next2 == w_hi) begin
                        o_step = w_neg;
                    end
                end
                MODE_WAIT_ALL: begin
                    w_stop = (w_sum <= w_lo) || (w_sum >= w_hi);
                    o_done = w_stop;
                    if (!w_stop) begin
                        o_color = w_sum[COLOR_W-1:0];
                    end
                end
                MODE_WAIT_DIR: begin
                    w_stop = (!i_step[COLOR_W-1] && w_sum >= w_target)
                          || (i_step[COLOR_W-1] && w_sum <= w_target);
                    o_done = w_stop;
                    if (!w_stop) begin
                        o_color = w_sum[COLOR_W-1:0];
                    end
                end
                default: begin
                    o_color = i_color;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

[sv/timed_color_channel_animator_unit.sv]
// timed color channel animator, top level
// uses tcca_pkg, tcca_in_if, tcca_out_if, tcca_accum and tcca_channel
//
// usage:
//   i_item carries items: kind 0 is a time tick with elapsed_time, kind 1
//   restarts the animation from the start registers. every item gives one
//   result on o_result: stepped (1 when the tick ran an animation step) and
//   colors_now, the packed colors after the item, channel 0 in the low byte.
//   write registers through i_cfg_we / i_cfg_idx / i_cfg_data only while the
//   block is idle (not enforced); an index beyond the list is ignored.
// timing:
//   an item sits in the input register while combinational logic
//   (accumulator add and compare, four channel adders) computes its result;
//   the result is captured in the result register, which drives o_result.
//   one item per cycle is accepted while results are taken.
// reset:
//   synchronous, active low; colors, steps, direction and accumulator clear,
//   registers take their reset values, both channels go empty.
// stall:
//   a held result stalls the input register, which then holds one more item;
//   after that i_item.ready drops until the result is taken.
`default_nettype none

module timed_color_channel_animator_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    tcca_in_if.sink                                i_item,
    tcca_out_if.source                             o_result,
    input  wire logic                              i_cfg_we,
    input  wire logic [tcca_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [tcca_pkg::CFG_DAT_W-1:0]    i_cfg_data
);
    import tcca_pkg::*;

    // configuration
    t_anim_mode          r_mode;
    logic [PERIOD_W-1:0] r_period;
    logic [PACK_W-1:0]   r_min;
    logic [PACK_W-1:0]   r_max;
    logic [PACK_W-1:0]   r_start_colors;
    logic [PACK_W-1:0]   r_start_steps;
    logic                r_start_dir;

    // animation state
    logic [COLOR_W-1:0]  r_color [CHANNELS];
    logic [COLOR_W-1:0]  r_step  [CHANNELS];
    logic                r_dir;
    logic [ACC_W-1:0]    r_acc;

    // input register
    logic                r_in_valid;
    logic                r_in_kind;
    logic [PERIOD_W-1:0] r_in_elapsed;

    // result register
    logic                r_out_valid;
    logic                r_out_stepped;
    logic [PACK_W-1:0]   r_out_colors;

    logic                w_advance;
    logic                w_in_xfer;
    logic [ACC_W-1:0]    w_acc_next;
    logic                w_step_due;
    t_chan_ctrl          w_ctrl;
    logic [COLOR_W-1:0]  w_ch_color [CHANNELS];
    logic [COLOR_W-1:0]  w_ch_step  [CHANNELS];
    logic [CHANNELS-1:0] w_ch_done;
    logic                w_wait_mode;
    logic                w_all_done;

    logic [COLOR_W-1:0]  n_color [CHANNELS];
    logic [COLOR_W-1:0]  n_step  [CHANNELS];
    logic                n_dir;
    logic [ACC_W-1:0]    n_acc;
    logic                n_stepped;
    logic [PACK_W-1:0]   n_colors;

    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;
    assign w_in_xfer    = i_item.valid && i_item.ready;

    assign o_result.valid      = r_out_valid;
    assign o_result.stepped    = r_out_stepped;
    assign o_result.colors_now = r_out_colors;

    assign w_ctrl.mode           = r_mode;
    assign w_ctrl.direction_down = r_dir;

    tcca_accum u_accum (
        .i_acc     (r_acc),
        .i_elapsed (r_in_elapsed),
        .i_period  (r_period),
        .o_acc     (w_acc_next),
        .o_step    (w_step_due)
    );

    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        tcca_channel u_channel (
            .i_ctrl  (w_ctrl),
            .i_color (r_color[g]),
            .i_step  (r_step[g]),
            .i_lo    (r_min[COLOR_W*g +: COLOR_W]),
            .i_hi    (r_max[COLOR_W*g +: COLOR_W]),
            .o_color (w_ch_color[g]),
            .o_step  (w_ch_step[g]),
            .o_done  (w_ch_done[g])
        );
    end

    always_comb begin
        w_wait_mode = (r_mode inside {MODE_WAIT_ALL, MODE_WAIT_DIR});
        w_all_done  = &w_ch_done;

        n_dir     = r_dir;
        n_acc     = r_acc;
        n_stepped = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            n_color[i] = r_color[i];
            n_step[i]  = r_step[i];
        end

        if (r_in_kind == KIND_RESTART) begin
            for (int i = 0; i < CHANNELS; i++) begin
                n_color[i] = r_start_colors[COLOR_W*i +: COLOR_W];
                n_step[i]  = r_start_steps[COLOR_W*i +: COLOR_W];
            end
            n_dir = r_start_dir;
        end else begin
            n_acc = w_acc_next;
            if (w_step_due) begin
                n_stepped = 1'b1;
                for (int i = 0; i < CHANNELS; i++) begin
                    n_color[i] = w_ch_color[i];
                    n_step[i]  = (w_wait_mode && w_all_done)
                               ? COLOR_W'(COLOR_W'(0) - r_step[i]) : w_ch_step[i];
                end
                if (w_all_done && r_mode == MODE_WAIT_DIR) begin
                    n_dir = !r_dir;
                end
            end
        end

        n_colors = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            n_colors[COLOR_W*i +: COLOR_W] = n_color[i];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_BOUNCE;
            r_period       <= RESET_PERIOD;
            r_min          <= RESET_MIN;
            r_max          <= RESET_MAX;
            r_start_colors <= '0;
            r_start_steps  <= '0;
            r_start_dir    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ANIM_MODE:       r_mode         <= t_anim_mode'(i_cfg_data[1:0]);
                CFG_UPDATE_PERIOD:   r_period       <= i_cfg_data[PERIOD_W-1:0];
                CFG_MIN_COLORS:      r_min          <= i_cfg_data[PACK_W-1:0];
                CFG_MAX_COLORS:      r_max          <= i_cfg_data[PACK_W-1:0];
                CFG_START_COLORS:    r_start_colors <= i_cfg_data[PACK_W-1:0];
                CFG_START_STEPS:     r_start_steps  <= i_cfg_data[PACK_W-1:0];
                CFG_START_DIRECTION: r_start_dir    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // animation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_color[i] <= '0;
                r_step[i]  <= '0;
            end
            r_dir <= 1'b0;
            r_acc <= '0;
        end else if (w_advance) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_color[i] <= n_color[i];
                r_step[i]  <= n_step[i];
            end
            r_dir <= n_dir;
            r_acc <= n_acc;
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_kind    <= i_item.kind;
            r_in_elapsed <= i_item.elapsed_time;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_stepped <= n_stepped;
            r_out_colors  <= n_colors;
        end
    end
endmodule

`default_nettype wire
